// ===== rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

   // fixed-point format of c and z: signed Q4.28
   localparam int Q_FRAC = 28;
   localparam int DATA_W = 32;

   // coordinate and size widths
   localparam int PIX_W  = 12;
   localparam int SIZE_W = 13;

   // mapping divider: |(max - min) * p| < 2^44
   localparam int DIVD_W = 44;
   localparam int DIVS_W = SIZE_W;

   // configuration port
   localparam int CSR_ADDR_W = 5;

   // iteration limit default
   localparam int ITER_LIMIT_DEF = 250;

   // escape bound 4.0 in the Q8.56 product format
   localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

   // color ramp steps
   localparam logic [8:0] RED_STEP   = 9'd10;
   localparam logic [8:0] GREEN_STEP = 9'd5;
   localparam logic [8:0] COLOR_MOD  = 9'd255;

   // register reset values
   localparam logic [31:0] X_MIN_RST = 32'hDC00_0000;
   localparam logic [31:0] X_MAX_RST = 32'h0C00_0000;
   localparam logic [31:0] Y_MIN_RST = 32'hE800_0000;
   localparam logic [31:0] Y_MAX_RST = 32'h1800_0000;
   localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd800;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd600;

   // register word indexes
   typedef enum logic [2:0] {
      CSR_X_MIN  = 3'd0,
      CSR_X_MAX  = 3'd1,
      CSR_Y_MIN  = 3'd2,
      CSR_Y_MAX  = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } csr_index_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic run;
      logic done;
   } div_stat_type;

   // clamp a wide signed value to the 32-bit Q4.28 range
   function automatic logic signed [31:0] sat_q32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return $signed(v[31:0]);
      end
   endfunction

endpackage

// ===== rtl/mbe_div.sv =====
`timescale 1ns / 1ps

module mbe_div import mbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic [DIVD_W-1:0] quotient,
   output div_stat_type      stat
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DIVD_W-1:0] quo_in;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVS_W-1:0] rem_in;
   logic [DIVS_W-1:0] dvs_ff;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   trial_sub;
   logic              q_bit;

   // restoring step: one quotient bit per cycle, msb first
   always_comb begin
      trial     = {rem_ff, quo_ff[DIVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      q_bit     = (trial >= {1'b0, dvs_ff});
      rem_in    = q_bit ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_in    = {quo_ff[DIVD_W-2:0], q_bit};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out as the quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.run  = run_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
`timescale 1ns / 1ps
// Mandelbrot escape-time engine for one pixel at a time.
// Command channel: drive req_pixel_x / req_pixel_y with start high; the word is
// taken at a clock edge where start is high and busy is low. busy then stays
// high until the result is out.
// Result channel: rsp_valid is high for exactly one cycle with rsp_red,
// rsp_green, rsp_blue and rsp_escape_count; the receiver cannot stall it, so
// it must take the word in that cycle. busy drops in the same cycle.
// The pixel is mapped to c with one multiply and one restoring divide per axis,
// then each escape-time iteration uses the single shared 33x33 multiplier for
// x*x, y*y and x*y in turn, and then does the update and bound test.
// Only one pixel is in flight; the next word can be taken in the cycle in
// which the result word is out.
// Configuration: APB-style registers at 4*i (view window in Q4.28, image
// width and height); write only while busy is low. pready is always high.
// Reset (synchronous, active high) restores the default view and size, ends
// any pixel in progress and drops rsp_valid and busy.

module mandelbrot_escape_time_pixel_top import mbe_pkg::*; #(
   parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [PIX_W-1:0]      req_pixel_x,
   input  logic [PIX_W-1:0]      req_pixel_y,
   // result channel
   output logic                  rsp_valid,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   output logic [7:0]            rsp_escape_count,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   localparam int ITER_W = $clog2(ITER_LIMIT + 1);
   localparam int CNT_W  = (ITER_W > 8) ? ITER_W : 8;

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_MULX      = 11'b000_0000_0010,
      S_DIVX_GO   = 11'b000_0000_0100,
      S_DIVX_WAIT = 11'b000_0000_1000,
      S_MULY      = 11'b000_0001_0000,
      S_DIVY_GO   = 11'b000_0010_0000,
      S_DIVY_WAIT = 11'b000_0100_0000,
      S_SQX       = 11'b000_1000_0000,
      S_SQY       = 11'b001_0000_0000,
      S_XY        = 11'b010_0000_0000,
      S_STEP      = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // configuration registers
   logic signed [31:0] x_min_ff;
   logic signed [31:0] x_max_ff;
   logic signed [31:0] y_min_ff;
   logic signed [31:0] y_max_ff;
   logic [SIZE_W-1:0]  width_ff;
   logic [SIZE_W-1:0]  height_ff;
   logic               csr_wr;

   // datapath
   logic [PIX_W-1:0]   px_ff;
   logic [PIX_W-1:0]   py_ff;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_neg;
   logic signed [63:0] prod_mag;
   logic               neg_ff;
   logic signed [32:0] diff_x;
   logic signed [32:0] diff_y;
   logic signed [63:0] xx_ff;
   logic signed [63:0] yy_ff;
   logic signed [31:0] cx_ff;
   logic signed [31:0] cy_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic [ITER_W-1:0]  iter_ff;
   logic [7:0]         rmod_ff;
   logic [7:0]         gmod_ff;
   logic [7:0]         rmod_in;
   logic [7:0]         gmod_in;
   logic [8:0]         rsum;
   logic [8:0]         gsum;

   // mapping divider
   logic               div_start;
   logic [DIVD_W-1:0]  div_quo;
   logic [DIVS_W-1:0]  div_dvs;
   div_stat_type       div_stat;
   logic signed [63:0] q_ext;
   logic signed [63:0] q_signed;
   logic signed [31:0] map_lo;
   logic signed [63:0] map_sum;
   logic signed [31:0] map_c;

   // iteration update
   logic [63:0]        mag_sum;
   logic               go_on;
   logic signed [63:0] sq_diff;
   logic signed [63:0] nx_wide;
   logic signed [63:0] ny_wide;
   logic               in_set;
   logic [CNT_W-1:0]   cnt_ext;

   // result word
   logic               rsp_valid_ff;
   logic [7:0]         red_ff;
   logic [7:0]         green_ff;
   logic [7:0]         blue_ff;
   logic [7:0]         count_ff;

   // register writes and reads
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= X_MIN_RST;
         x_max_ff  <= X_MAX_RST;
         y_min_ff  <= Y_MIN_RST;
         y_max_ff  <= Y_MAX_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_index_type'(paddr[4:2]))
            CSR_X_MIN:  x_min_ff  <= pwdata;
            CSR_X_MAX:  x_max_ff  <= pwdata;
            CSR_Y_MIN:  y_min_ff  <= pwdata;
            CSR_Y_MAX:  y_max_ff  <= pwdata;
            CSR_WIDTH:  width_ff  <= pwdata[SIZE_W-1:0];
            CSR_HEIGHT: height_ff <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(paddr[4:2]))
         CSR_X_MIN:  prdata = x_min_ff;
         CSR_X_MAX:  prdata = x_max_ff;
         CSR_Y_MIN:  prdata = y_min_ff;
         CSR_Y_MAX:  prdata = y_max_ff;
         CSR_WIDTH:  prdata = DATA_W'(width_ff);
         CSR_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // window spans, 33-bit so they never wrap
   assign diff_x = {x_max_ff[31], x_max_ff} - {x_min_ff[31], x_min_ff};
   assign diff_y = {y_max_ff[31], y_max_ff} - {y_min_ff[31], y_min_ff};

   // sequencer and shared multiplier operand select
   always_comb begin
      state_in  = state_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_MULX;
         end
         S_MULX: begin
            mul_a    = diff_x;
            mul_b    = $signed(33'(px_ff));
            state_in = S_DIVX_GO;
         end
         S_DIVX_GO: begin
            div_start = 1'b1;
            state_in  = S_DIVX_WAIT;
         end
         S_DIVX_WAIT: begin
            if (div_stat.done) state_in = S_MULY;
         end
         S_MULY: begin
            mul_a    = diff_y;
            mul_b    = $signed(33'(py_ff));
            state_in = S_DIVY_GO;
         end
         S_DIVY_GO: begin
            div_start = 1'b1;
            state_in  = S_DIVY_WAIT;
         end
         S_DIVY_WAIT: begin
            if (div_stat.done) state_in = S_SQX;
         end
         S_SQX: begin
            mul_a    = {x_ff[31], x_ff};
            mul_b    = {x_ff[31], x_ff};
            state_in = S_SQY;
         end
         S_SQY: begin
            mul_a    = {y_ff[31], y_ff};
            mul_b    = {y_ff[31], y_ff};
            state_in = S_XY;
         end
         S_XY: begin
            mul_a    = {x_ff[31], x_ff};
            mul_b    = {y_ff[31], y_ff};
            state_in = S_STEP;
         end
         S_STEP: begin
            state_in = go_on ? S_SQX : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // divider feed: magnitude of the span product, divisor 0 taken as 1
   assign prod_neg = -prod_ff;
   assign prod_mag = prod_ff[63] ? prod_neg : prod_ff;
   always_comb begin
      if (state_ff == S_DIVX_GO) begin
         div_dvs = (width_ff == '0) ? DIVS_W'(1) : width_ff;
      end else begin
         div_dvs = (height_ff == '0) ? DIVS_W'(1) : height_ff;
      end
   end

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[DIVD_W-1:0]),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // c = min + trunc(span * p / size), clamped
   assign q_ext    = $signed({{(64 - DIVD_W){1'b0}}, div_quo});
   assign q_signed = neg_ff ? -q_ext : q_ext;
   assign map_lo   = (state_ff == S_DIVX_WAIT) ? x_min_ff : y_min_ff;
   assign map_sum  = $signed({{32{map_lo[31]}}, map_lo}) + q_signed;
   assign map_c    = sat_q32(map_sum);

   // bound test and next z from the three products
   assign mag_sum = $unsigned(xx_ff) + $unsigned(yy_ff);
   assign go_on   = (mag_sum <= ESC_LIMIT) && (iter_ff < ITER_W'(ITER_LIMIT));
   assign sq_diff = xx_ff - yy_ff;
   assign nx_wide = (sq_diff >>> Q_FRAC) + $signed({{32{cx_ff[31]}}, cx_ff});
   assign ny_wide = (prod_ff >>> (Q_FRAC - 1)) + $signed({{32{cy_ff[31]}}, cy_ff});
   assign x_in    = sat_q32(nx_wide);
   assign y_in    = sat_q32(ny_wide);

   // running (n*10) mod 255 and (n*5) mod 255
   assign rsum    = {1'b0, rmod_ff} + RED_STEP;
   assign gsum    = {1'b0, gmod_ff} + GREEN_STEP;
   assign rmod_in = (rsum >= COLOR_MOD) ? 8'(rsum - COLOR_MOD) : rsum[7:0];
   assign gmod_in = (gsum >= COLOR_MOD) ? 8'(gsum - COLOR_MOD) : gsum[7:0];

   assign in_set  = (iter_ff == ITER_W'(ITER_LIMIT));
   assign cnt_ext = CNT_W'(iter_ff);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_STEP) && !go_on;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= $signed(mul_p[63:0]);
      if (state_ff == S_IDLE && start) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
      if (state_ff == S_DIVX_GO || state_ff == S_DIVY_GO) begin
         neg_ff <= prod_ff[63];
      end
      if (state_ff == S_DIVX_WAIT && div_stat.done) begin
         cx_ff <= map_c;
      end
      if (state_ff == S_DIVY_WAIT && div_stat.done) begin
         cy_ff   <= map_c;
         x_ff    <= '0;
         y_ff    <= '0;
         iter_ff <= '0;
         rmod_ff <= '0;
         gmod_ff <= '0;
      end
      if (state_ff == S_SQY) begin
         xx_ff <= prod_ff;
      end
      if (state_ff == S_XY) begin
         yy_ff <= prod_ff;
      end
      if (state_ff == S_STEP) begin
         if (go_on) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            iter_ff <= iter_ff + ITER_W'(1);
            rmod_ff <= rmod_in;
            gmod_ff <= gmod_in;
         end else begin
            red_ff   <= in_set ? 8'd0 : 8'hFF - rmod_ff;
            green_ff <= in_set ? 8'd0 : 8'hFF - gmod_ff;
            blue_ff  <= in_set ? 8'd0 : 8'hFF;
            count_ff <= (cnt_ext > CNT_W'(255)) ? 8'hFF : cnt_ext[7:0];
         end
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_escape_count = count_ff;

`ifndef SYNTH
   // a result word only follows a failed bound test
   a_rsp_after_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_STEP))
      else $error("result word without a finished iteration");

   // iteration count stays within the limit
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQX || state_ff == S_SQY || state_ff == S_XY || state_ff == S_STEP)
         |-> (iter_ff <= ITER_W'(ITER_LIMIT)))
      else $error("iteration count past limit");

   // color residues stay below the modulus
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (rmod_ff < 8'd255 && gmod_ff < 8'd255))
      else $error("color residue out of range");

   // the divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_stat.run || div_stat.done)
         |-> (state_ff == S_DIVX_WAIT || state_ff == S_DIVY_WAIT))
      else $error("divider active outside a wait state");
`endif

endmodule
